// ===== rtl/core/mssc_pkg.sv =====
// ============================================================================
// mssc_pkg
// Shared widths, defaults and the result handoff type for the minimum
// square-sum count block.
// ============================================================================
package mssc_pkg;

    // payload widths
    localparam int AREA_W  = 17;
    localparam int LIMIT_W = 18;
    localparam int COUNT_W = 3;

    // default table depth and limit after reset
    localparam int                 DEF_MAX_AREA = 131072;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 18'd100000;

    // start value of the running minimum, above any real count
    localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_ZERO = 3'd0;

    // finished result handed from the controller to the output stage
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] square_count;
        logic               rejected;
    } result_t;

endpackage

// ===== rtl/core/mssc_if.sv =====
// ============================================================================
// mssc_if
// Valid/ready channels for area requests and count responses.
// ============================================================================
interface mssc_req_if;
    logic                         valid;
    logic                         ready;
    logic [mssc_pkg::AREA_W-1:0]  area;

    modport source (output valid, output area, input ready);
    modport sink   (input valid, input area, output ready);
endinterface

interface mssc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mssc_pkg::COUNT_W-1:0] square_count;
    logic                         rejected;

    modport source (output valid, output square_count, output rejected, input ready);
    modport sink   (input valid, input square_count, input rejected, output ready);
endinterface

// ===== rtl/core/mssc_mem.sv =====
// ============================================================================
// mssc_mem
// Count table: one write port, one read port, registered read data.
// ============================================================================
module mssc_mem #(
    parameter int DEPTH = mssc_pkg::DEF_MAX_AREA,
    parameter int AW    = $clog2(mssc_pkg::DEF_MAX_AREA)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [mssc_pkg::COUNT_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [mssc_pkg::COUNT_W-1:0] rd_data
);

    logic [mssc_pkg::COUNT_W-1:0] mem [DEPTH];
    logic [mssc_pkg::COUNT_W-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mssc_ctrl.sv =====
// ============================================================================
// mssc_ctrl
// Sequencer: limit check, table extension by read-min-write, table lookup.
// ============================================================================
module mssc_ctrl #(
    parameter int MAX_AREA = mssc_pkg::DEF_MAX_AREA,
    parameter int AW       = $clog2(mssc_pkg::DEF_MAX_AREA)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mssc_req_if.sink                      req,
    input  logic [mssc_pkg::LIMIT_W-1:0]  area_limit,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic [mssc_pkg::COUNT_W-1:0]  rd_data,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [mssc_pkg::COUNT_W-1:0]  wr_data,
    output mssc_pkg::result_t             res,
    input  logic                          res_ready
);

    localparam int CMPW = (AW + 1 > mssc_pkg::LIMIT_W) ? AW + 1 : mssc_pkg::LIMIT_W;
    localparam int CW   = mssc_pkg::COUNT_W;

    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_AREA);
    localparam logic [AW:0]     SQ_FIRST  = (AW + 1)'(1);
    localparam logic [AW:0]     ODD_FIRST = (AW + 1)'(3);
    localparam logic [AW:0]     ODD_STEP  = (AW + 1)'(2);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXT_INIT = 3'd1;
    localparam logic [2:0] S_EXT_RD   = 3'd2;
    localparam logic [2:0] S_EXT_WR   = 3'd3;
    localparam logic [2:0] S_RD_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]    state_reg,  state_next;
    logic [AW:0]   filled_reg, filled_next;
    logic [AW-1:0] area_reg,   area_next;
    logic [AW-1:0] m_reg,      m_next;
    logic [AW:0]   sq_reg,     sq_next;
    logic [AW:0]   odd_reg,    odd_next;
    logic [CW-1:0] best_reg,   best_next;
    logic          pend_reg,   pend_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic          rej_reg,    rej_next;

    logic [CMPW-1:0] area_ext;
    logic [CMPW-1:0] limit_ext;
    logic [CMPW-1:0] filled_ext;
    logic            is_rejected;
    logic [CW:0]     cand;
    logic [AW:0]     diff;

    assign area_ext    = CMPW'(req.area);
    assign limit_ext   = CMPW'(area_limit);
    assign filled_ext  = CMPW'(filled_reg);
    assign is_rejected = (area_ext >= limit_ext) || (area_ext >= MAX_C);
    assign cand        = {1'b0, rd_data} + (CW + 1)'(1);
    assign diff        = {1'b0, m_reg} - sq_reg;

    // next-state and memory control
    always_comb
    begin
        state_next  = state_reg;
        filled_next = filled_reg;
        area_next   = area_reg;
        m_next      = m_reg;
        sq_next     = sq_reg;
        odd_next    = odd_reg;
        best_next   = best_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        rej_next    = rej_reg;
        req.ready   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = area_ext[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = m_reg;
        wr_data     = best_reg;
        res.valid        = 1'b0;
        res.square_count = cnt_reg;
        res.rejected     = rej_reg;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    area_next = area_ext[AW-1:0];
                    if (is_rejected)
                    begin
                        cnt_next   = mssc_pkg::COUNT_ZERO;
                        rej_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (area_ext >= filled_ext)
                    begin
                        m_next     = filled_reg[AW-1:0];
                        state_next = S_EXT_INIT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_RD_WAIT;
                    end
                end
            end

            // start a new entry m; entry 0 is written directly
            S_EXT_INIT:
            begin
                best_next = mssc_pkg::COUNT_NONE;
                sq_next   = SQ_FIRST;
                odd_next  = ODD_FIRST;
                pend_next = 1'b0;
                if (m_reg == '0)
                begin
                    wr_en       = 1'b1;
                    wr_data     = mssc_pkg::COUNT_ZERO;
                    filled_next = (AW + 1)'(1);
                    if (area_reg == '0)
                    begin
                        cnt_next   = mssc_pkg::COUNT_ZERO;
                        rej_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        m_next = AW'(1);
                    end
                end
                else
                begin
                    state_next = S_EXT_RD;
                end
            end

            // one read of table[m - k*k] per cycle, the data folded in the cycle after its read
            S_EXT_RD:
            begin
                if (pend_reg && (cand < {1'b0, best_reg}))
                begin
                    best_next = cand[CW-1:0];
                end
                if (sq_reg <= {1'b0, m_reg})
                begin
                    rd_en     = 1'b1;
                    rd_addr   = diff[AW-1:0];
                    sq_next   = sq_reg + odd_reg;
                    odd_next  = odd_reg + ODD_STEP;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_EXT_WR;
                end
            end

            // store the minimum; it is the answer when m reached the request
            S_EXT_WR:
            begin
                wr_en       = 1'b1;
                filled_next = {1'b0, m_reg} + (AW + 1)'(1);
                if (m_reg == area_reg)
                begin
                    cnt_next   = best_reg;
                    rej_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    m_next     = m_reg + AW'(1);
                    state_next = S_EXT_INIT;
                end
            end

            S_RD_WAIT:
            begin
                cnt_next   = rd_data;
                rej_next   = 1'b0;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            filled_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            pend_reg   <= pend_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
        m_reg    <= m_next;
        sq_reg   <= sq_next;
        odd_reg  <= odd_next;
        best_reg <= best_next;
        cnt_reg  <= cnt_next;
        rej_reg  <= rej_next;
    end

    // table reads stay below the high-water mark
    a_rd_filled: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> ({1'b0, rd_addr} < filled_reg))
        else $error("table read at or above filled mark");

    // table grows strictly in order
    a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_addr} == filled_reg))
        else $error("table write out of order");

    // stored counts never exceed four
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_data <= CW'(4)))
        else $error("count out of range written");

    // high-water mark never falls
    a_filled_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (filled_reg >= $past(filled_reg)))
        else $error("filled mark decreased");

endmodule

// ===== rtl/core/min_square_sum_count_core.sv =====
// ============================================================================
// min_square_sum_count_core
// Fewest perfect squares summing to a requested area, from a growing table.
// ============================================================================
// Usage:
//   req carries one area per request (valid/ready); rsp returns one
//   square_count and rejected flag per request, in order.
//   cfg_we/cfg_wdata write area_limit (reset 100000); write it only while idle.
//   An area at or above area_limit or MAX_AREA comes back rejected, count 0.
// Sequence:
//   Rejected request: goes straight to the done state. Area already in the
//   table: one read, a wait for the read data, then done. Otherwise the
//   table is extended up to the area first: entry 0 in a single write, each
//   later entry m by one read per candidate square, then a write, before
//   the done state and the output register. One request is in work at a time;
//   the controller returns to idle as the last response enters the output reg.
// Reset: the table is empty (high-water mark 0), no clearing pass is needed.
// Stall: a held response blocks delivery of the next; the request side then
//   holds ready low until the output register drains.
// ============================================================================
module min_square_sum_count_core #(
    parameter int MAX_AREA = mssc_pkg::DEF_MAX_AREA
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mssc_pkg::LIMIT_W-1:0] cfg_wdata,
    mssc_req_if.sink                     req,
    mssc_rsp_if.source                   rsp
);

    localparam int AW = $clog2(MAX_AREA);

    logic [mssc_pkg::LIMIT_W-1:0] limit_reg;
    logic                         out_valid_reg;
    logic [mssc_pkg::COUNT_W-1:0] out_count_reg;
    logic                         out_rej_reg;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [mssc_pkg::COUNT_W-1:0] rd_data;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [mssc_pkg::COUNT_W-1:0] wr_data;
    mssc_pkg::result_t            res;
    logic                         res_ready;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= mssc_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    mssc_ctrl #(
        .MAX_AREA (MAX_AREA),
        .AW       (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .area_limit (limit_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res        (res),
        .res_ready  (res_ready)
    );

    mssc_mem #(
        .DEPTH (MAX_AREA),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_count_reg <= res.square_count;
            out_rej_reg   <= res.rejected;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.square_count = out_count_reg;
    assign rsp.rejected     = out_rej_reg;

endmodule
